>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file ttui_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is high.
`define TTUI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Same check, expressed through the generic form above.
`define TTUI_ASSERT_CLK(label, prop) \
   `TTUI_ASSERT(label, clock, reset, prop)

`endif

>>> hw/rtl/ttui_pkg.sv
package ttui_pkg;

   localparam int CharW   = 8;
   localparam int RadixW  = 6;
   localparam int NumW    = 64;
   localparam int StopW   = 16;
   localparam int StatusW = 2;

   localparam logic [RadixW-1:0] RadixReset = 6'd10;
   localparam logic [RadixW-1:0] RadixMax   = 6'd36;
   localparam logic [RadixW-1:0] RadixOct   = 6'd8;
   localparam logic [RadixW-1:0] RadixDec   = 6'd10;
   localparam logic [RadixW-1:0] RadixHex   = 6'd16;
   localparam logic [RadixW-1:0] RadixBin   = 6'd2;
   localparam logic [RadixW-1:0] NoDigit    = 6'd63;

   localparam logic [CharW-1:0] ChNul    = 8'h00;
   localparam logic [CharW-1:0] ChSpace  = 8'h20;
   localparam logic [CharW-1:0] ChTab    = 8'h09;
   localparam logic [CharW-1:0] ChCr     = 8'h0d;
   localparam logic [CharW-1:0] ChMinus  = 8'h2d;
   localparam logic [CharW-1:0] ChPlus   = 8'h2b;
   localparam logic [CharW-1:0] ChZero   = 8'h30;
   localparam logic [CharW-1:0] ChNine   = 8'h39;
   localparam logic [CharW-1:0] ChUpperA = 8'h41;
   localparam logic [CharW-1:0] ChUpperZ = 8'h5a;
   localparam logic [CharW-1:0] ChLowerA = 8'h61;
   localparam logic [CharW-1:0] ChLowerZ = 8'h7a;
   localparam logic [CharW-1:0] ChUpperX = 8'h58;
   localparam logic [CharW-1:0] ChLowerX = 8'h78;
   localparam logic [CharW-1:0] ChUpperB = 8'h42;
   localparam logic [CharW-1:0] ChLowerB = 8'h62;

   typedef enum logic [StatusW-1:0] {
      StatOk       = 2'd0,
      StatNoDigits = 2'd1,
      StatOverflow = 2'd2,
      StatBadBase  = 2'd3
   } status_type;

   function automatic logic radix_bad(input logic [RadixW-1:0] r);
      return (r == 6'd1) || (r > RadixMax);
   endfunction

   // Digit value of a character; letters count from ten, anything else is NoDigit.
   function automatic logic [RadixW-1:0] digit_of(input logic [CharW-1:0] c);
      logic [CharW-1:0] d;
      begin
         d = ChNul;
         if (c >= ChZero && c <= ChNine) begin
            d = c - ChZero;
         end else if (c >= ChUpperA && c <= ChUpperZ) begin
            d = c - ChUpperA + 8'd10;
         end else if (c >= ChLowerA && c <= ChLowerZ) begin
            d = c - ChLowerA + 8'd10;
         end else begin
            d = CharW'(NoDigit);
         end
         return d[RadixW-1:0];
      end
   endfunction

endpackage

>>> hw/rtl/text_to_unsigned_integer.sv
// Converts a byte stream into unsigned integers, one string per NUL-terminated
// run: leading whitespace, an optional sign, an optional 0x/0b prefix (or a
// leading 0 for octal when the radix register is 0), then digits in the chosen
// base into a 64-bit value that saturates to all ones on overflow. One byte is
// taken every clock cycle with no gaps between strings; the result word appears
// on the rsp side the cycle after the NUL is accepted, from an output register.
// The req side stalls only while a result word waits with rsp_tready low. The
// cycle path is one 64x6 multiply-add with its overflow compare. Write the radix
// only while no string is in progress.
module text_to_unsigned_integer #(
   parameter longint unsigned POSITION_LIMIT = 64'd65535
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_wdata,   // radix
   // characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [63:0] number, [79:64] stop_index
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int PosW = $clog2(POSITION_LIMIT + 64'd1);
   localparam int ExtW = (PosW > ttui_pkg::StopW) ? PosW : ttui_pkg::StopW;
   localparam int ProdW = ttui_pkg::NumW + ttui_pkg::RadixW;

   typedef enum logic [2:0] {
      PhWs, PhSign, PhZero, PhPrefix, PhDigits, PhDone
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic                         minus_ff, minus_in;
   logic [ttui_pkg::RadixW-1:0]  base_ff, base_in;
   logic [ttui_pkg::NumW-1:0]    acc_ff, acc_in;
   logic                         ovf_ff, ovf_in;
   logic [PosW-1:0]              pos_ff, pos_next;
   logic [PosW-1:0]              pend_ff, pend_in;
   logic [ttui_pkg::RadixW-1:0]  radix_ff;

   logic                         out_valid_ff;
   logic [ttui_pkg::NumW-1:0]    number_ff, number_in;
   logic [ttui_pkg::StopW-1:0]   stop_ff, stop_in;
   ttui_pkg::status_type         status_ff, status_in;

   logic                         accept;
   logic                         is_nul;
   logic                         is_ws;
   logic                         start;
   logic                         do_digit;
   logic [ttui_pkg::RadixW-1:0]  digit_base;
   logic [ttui_pkg::RadixW-1:0]  dval;
   logic [ProdW-1:0]             prod;
   logic [ExtW-1:0]              pend_ext;

   assign csr_ready  = 1'b1;
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_nul     = (req_tdata == ttui_pkg::ChNul);
   assign is_ws      = (req_tdata == ttui_pkg::ChSpace) ||
                       (req_tdata >= ttui_pkg::ChTab && req_tdata <= ttui_pkg::ChCr);
   assign dval       = ttui_pkg::digit_of(req_tdata);
   assign pos_next   = (pos_ff == PosW'(POSITION_LIMIT)) ? pos_ff : pos_ff + 1'b1;
   assign prod       = ProdW'(acc_ff) * ProdW'(digit_base) + ProdW'(dval);

   // Per-character parse step.
   always_comb begin
      phase_in   = phase_ff;
      minus_in   = minus_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      ovf_in     = ovf_ff;
      pend_in    = pend_ff;
      start      = 1'b0;
      do_digit   = 1'b0;
      digit_base = base_ff;
      unique case (phase_ff)
         PhWs: begin
            if (is_ws) begin
               phase_in = phase_ff;
            end else if (req_tdata == ttui_pkg::ChMinus || req_tdata == ttui_pkg::ChPlus) begin
               minus_in = (req_tdata == ttui_pkg::ChMinus);
               phase_in = PhSign;
            end else begin
               start = 1'b1;
            end
         end
         PhSign: start = 1'b1;
         PhZero: begin
            if ((req_tdata == ttui_pkg::ChLowerX || req_tdata == ttui_pkg::ChUpperX) &&
                (base_ff == '0 || base_ff == ttui_pkg::RadixHex)) begin
               base_in  = ttui_pkg::RadixHex;
               phase_in = PhPrefix;
            end else if ((req_tdata == ttui_pkg::ChLowerB || req_tdata == ttui_pkg::ChUpperB) &&
                         (base_ff == '0 || base_ff == ttui_pkg::RadixBin)) begin
               base_in  = ttui_pkg::RadixBin;
               phase_in = PhPrefix;
            end else begin
               digit_base = (base_ff == '0) ? ttui_pkg::RadixOct : base_ff;
               base_in    = digit_base;
               do_digit   = 1'b1;
            end
         end
         PhPrefix, PhDigits: do_digit = 1'b1;
         default: phase_in = phase_ff;
      endcase

      if (start) begin
         if (ttui_pkg::radix_bad(radix_ff)) begin
            base_in  = radix_ff;
            phase_in = PhDone;
         end else if (req_tdata == ttui_pkg::ChZero) begin
            base_in  = radix_ff;
            acc_in   = '0;
            pend_in  = pos_next;
            phase_in = PhZero;
         end else begin
            digit_base = (radix_ff == '0) ? ttui_pkg::RadixDec : radix_ff;
            base_in    = digit_base;
            do_digit   = 1'b1;
         end
      end

      if (do_digit) begin
         if (digit_base < ttui_pkg::RadixBin || dval >= digit_base) begin
            phase_in = PhDone;
         end else begin
            // keep the old value once the product no longer fits
            if (prod[ProdW-1:ttui_pkg::NumW] != '0) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = prod[ttui_pkg::NumW-1:0];
            end
            pend_in  = pos_next;
            phase_in = PhDigits;
         end
      end
   end

   // Result for a NUL arriving now.
   always_comb begin
      pend_ext  = ExtW'(pend_ff);
      number_in = '0;
      stop_in   = '0;
      if (phase_ff == PhWs || phase_ff == PhSign) begin
         status_in = ttui_pkg::radix_bad(radix_ff) ? ttui_pkg::StatBadBase
                                                   : ttui_pkg::StatNoDigits;
      end else if (ttui_pkg::radix_bad(base_ff) && phase_ff == PhDone) begin
         status_in = ttui_pkg::StatBadBase;
      end else if (pend_ff == '0) begin
         status_in = ttui_pkg::StatNoDigits;
      end else if (ovf_ff) begin
         status_in = ttui_pkg::StatOverflow;
         number_in = '1;
         stop_in   = pend_ext[ttui_pkg::StopW-1:0];
      end else begin
         status_in = ttui_pkg::StatOk;
         number_in = minus_ff ? (ttui_pkg::NumW'(0) - acc_ff) : acc_ff;
         stop_in   = pend_ext[ttui_pkg::StopW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhWs;
         minus_ff     <= 1'b0;
         base_ff      <= '0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         pend_ff      <= '0;
         radix_ff     <= ttui_pkg::RadixReset;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            radix_ff <= csr_wdata;
         end
         if (accept && is_nul) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (is_nul) begin
               number_ff    <= number_in;
               stop_ff      <= stop_in;
               status_ff    <= status_in;
               // back to whitespace skipping for the next string
               phase_ff     <= PhWs;
               minus_ff     <= 1'b0;
               base_ff      <= '0;
               acc_ff       <= '0;
               ovf_ff       <= 1'b0;
               pos_ff       <= '0;
               pend_ff      <= '0;
            end else begin
               phase_ff <= phase_in;
               minus_ff <= minus_in;
               base_ff  <= base_in;
               acc_ff   <= acc_in;
               ovf_ff   <= ovf_in;
               pos_ff   <= pos_next;
               pend_ff  <= pend_in;
            end
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {stop_ff, number_ff};
   assign rsp_tuser  = status_ff;

endmodule

>>> hw/rtl/ttui_checker.sv
`include "assert_macros.svh"

module ttui_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic rsp_stall;
   logic nul_fire;
   logic rsp_empty;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign nul_fire  = req_tvalid && req_tready && req_tdata == ttui_pkg::ChNul;
   assign rsp_empty = rsp_tuser == ttui_pkg::StatNoDigits || rsp_tuser == ttui_pkg::StatBadBase;

   // a stalled result word holds
   `TTUI_ASSERT_CLK(rsp_hold_a, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a fresh result word follows an accepted NUL
   `TTUI_ASSERT_CLK(rsp_after_nul_a, rsp_tvalid && !$past(rsp_stall) |-> $past(nul_fire))

   // overflow saturates the number
   `TTUI_ASSERT_CLK(ovf_ones_a, rsp_tvalid && rsp_tuser == ttui_pkg::StatOverflow |-> &rsp_tdata[63:0])

   // no digits or a bad base report zero value and zero stop index
   `TTUI_ASSERT_CLK(empty_zero_a, rsp_tvalid && rsp_empty |-> rsp_tdata == 80'd0)

endmodule

bind text_to_unsigned_integer ttui_checker u_ttui_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
